@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the k-mer counter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define KMCH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define KMCH_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/kmch_pkg.sv @@
// Shared constants, types and base encoding for the k-mer count hash table.
package kmch_pkg;

    localparam int DEFAULT_TABLE_SLOTS  = 4096;
    localparam int DEFAULT_MAX_KMER_LEN = 31;

    localparam int CFG_W      = 13;
    localparam int CHAR_W     = 8;
    localparam int ADD_W      = 16;
    localparam int HASH_W     = 32;
    localparam int CNT_W      = 32;
    localparam int OUT_SLOT_W = 13;
    localparam int OUT_DIST_W = 13;

    localparam logic [CFG_W-1:0]  SLOTS_RESET = 13'd4096;
    localparam logic [HASH_W-1:0] HASH_MULT   = 32'd65599;

    localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
    localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
    localparam logic [CHAR_W-1:0] CHAR_N = 8'h4E;
    localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

    localparam logic [1:0] CODE_A = 2'd0;
    localparam logic [1:0] CODE_G = 2'd1;
    localparam logic [1:0] CODE_C = 2'd2;
    localparam logic [1:0] CODE_T = 2'd3;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    // A and N map to zero, as does any byte that is not a nucleotide.
    function automatic logic [1:0] base_code(input logic [CHAR_W-1:0] ch);
        logic [1:0] code;
        case (ch)
            CHAR_G:  code = CODE_G;
            CHAR_C:  code = CODE_C;
            CHAR_T:  code = CODE_T;
            CHAR_A:  code = CODE_A;
            CHAR_N:  code = CODE_A;
            default: code = CODE_A;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/kmch_ram.sv @@
// Generic single-port RAM with registered read data.
module kmch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ hw/rtl/kmch_accum.sv @@
// Rolling hash and 2-bit base packing for the k-mer being streamed in.
module kmch_accum
    import kmch_pkg::*;
#(
    parameter int MAX_KMER_LEN = DEFAULT_MAX_KMER_LEN,
    localparam int KEY_W       = 2 * MAX_KMER_LEN + 1,
    localparam int PW          = $clog2(MAX_KMER_LEN + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              clear,
    input  logic [CHAR_W-1:0] base_char,
    output logic [HASH_W-1:0] hash,
    output logic [KEY_W-1:0]  key
);

    logic [HASH_W-1:0]         hash_reg;
    logic [HASH_W-1:0]         hash_next;
    logic [2*MAX_KMER_LEN-1:0] packed_reg;
    logic [2*MAX_KMER_LEN-1:0] packed_next;
    logic [PW-1:0]             pos_reg;
    logic [PW-1:0]             pos_next;
    logic [1:0]                code;

    always_comb
    begin
        code        = base_code(base_char);
        hash_next   = hash_reg * HASH_MULT + HASH_W'(base_char);
        packed_next = packed_reg;
        pos_next    = pos_reg;
        // Bytes past the maximum length still hash but are not packed.
        if (pos_reg < PW'(MAX_KMER_LEN))
        begin
            pos_next = pos_reg + 1'b1;
            for (int i = 0; i < MAX_KMER_LEN; i++)
            begin
                if (pos_reg == PW'(i))
                begin
                    packed_next[2*i +: 2] = packed_reg[2*i +: 2] | code;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg   <= '0;
            packed_reg <= '0;
            pos_reg    <= '0;
        end
        else if (clear)
        begin
            hash_reg   <= '0;
            packed_reg <= '0;
            pos_reg    <= '0;
        end
        else if (accept)
        begin
            hash_reg   <= hash_next;
            packed_reg <= packed_next;
            pos_reg    <= pos_next;
        end
    end

    assign hash = hash_reg;
    assign key  = KEY_W'(packed_reg) + 1'b1;

endmodule

@@ hw/rtl/kmch_div.sv @@
// Bit-serial restoring divider that returns the remainder only.
`include "assert_macros.svh"

module kmch_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 13,
    localparam int CW        = $clog2(DIVIDEND_W + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVISOR_W-1:0]  remainder
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic [DIVISOR_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff  = trial - {1'b0, div_reg};
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = diff[DIVISOR_W-1:0];
        end
        else
        begin
            rem_next = trial[DIVISOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle; the quotient itself is dropped.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    `KMCH_ASSERT_IMPL(a_rem_below_divisor, done_reg, rem_reg < div_reg,
        "remainder not below divisor")

endmodule

@@ hw/rtl/kmer_count_hash_table_top.sv @@
// Top level of the k-mer count hash table: sequencer, probe walk and result register.
//
// Usage: stream a k-mer as one ASCII base per word on the input channel
// (in_valid / in_stall), with last_char set on its final byte. mode and
// add_count count only on that final word. Non-final words are taken as
// soon as offered while the block is idle. After the final word the block
// stalls its input while it reduces the hash modulo slots_in_use on a
// one-bit-per-cycle divider and walks the table, with a RAM read step and a
// compare step per probed slot, then an update step and a step that loads
// the result. A full table costs a probe of every one of the slots_in_use
// slots. One result word per k-mer leaves on out_valid / out_stall; the
// result register holds it while out_stall is high. in_stall stays high
// from the final word until the new result is loaded, and the load step
// waits while an older result is still held, so a stalled receiver backs
// the block up into its input. After reset the key/count RAM is cleared,
// one slot per cycle; in_stall stays high during that pass. The user must
// write slots_in_use through cfg_wr_en / cfg_wr_data only while the block
// is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module kmer_count_hash_table_top
    import kmch_pkg::*;
#(
    parameter int TABLE_SLOTS  = DEFAULT_TABLE_SLOTS,
    parameter int MAX_KMER_LEN = DEFAULT_MAX_KMER_LEN
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_W-1:0]      cfg_wr_data,
    // input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [CHAR_W-1:0]     base_char,
    input  logic                  last_char,
    input  logic [ADD_W-1:0]      add_count,
    // output channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_SLOT_W-1:0] slot_plus_one,
    output logic                  was_new,
    output logic                  table_full,
    output logic [OUT_DIST_W-1:0] distinct_count,
    output logic [CNT_W-1:0]      slot_count
);

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int NW     = SLOT_W + 1;
    localparam int DW     = $clog2(TABLE_SLOTS + 1);
    localparam int KEY_W  = 2 * MAX_KMER_LEN + 1;
    localparam int RAM_W  = KEY_W + CNT_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_UPDATE,
        ST_PUBLISH
    } state_t;

    state_t              state_reg;
    logic [CFG_W-1:0]    slots_in_use_reg;
    logic [SLOT_W-1:0]   clr_addr_reg;
    logic [NW-1:0]       n_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic [NW-1:0]       probe_cnt_reg;
    mode_t               mode_reg;
    logic [ADD_W-1:0]    add_reg;
    logic                hit_match_reg;
    logic                hit_empty_reg;
    logic [CNT_W-1:0]    hit_cnt_reg;
    logic                full_reg;
    logic [DW-1:0]       distinct_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic                res_found_reg;
    logic                res_new_reg;
    logic [CNT_W-1:0]    res_cnt_reg;
    logic                out_valid_reg;
    logic [OUT_SLOT_W-1:0] out_slot_reg;
    logic                out_new_reg;
    logic                out_full_reg;
    logic [OUT_DIST_W-1:0] out_dist_reg;
    logic [CNT_W-1:0]    out_cnt_reg;

    logic                in_acc;
    logic                out_free;
    logic                acc_clear;
    logic [HASH_W-1:0]   acc_hash;
    logic [KEY_W-1:0]    acc_key;
    logic                div_start;
    logic                div_done;
    logic [NW-1:0]       div_rem;
    logic [NW-1:0]       n_next;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_addr;
    logic [RAM_W-1:0]    ram_wdata;
    logic [RAM_W-1:0]    ram_rdata;
    logic [KEY_W-1:0]    rd_key;
    logic [CNT_W-1:0]    rd_cnt;
    logic                rd_match;
    logic                rd_empty;
    logic [NW-1:0]       idx_inc;
    logic [CNT_W:0]      sum_wide;
    logic [CNT_W-1:0]    sum_sat;
    logic                do_insert;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign acc_clear = (state_reg == ST_PUBLISH) && out_free;
    assign div_start = (state_reg == ST_DIV_GO);

    // Clamp the slot count: zero acts as one, oversize acts as the full table.
    always_comb
    begin
        if (slots_in_use_reg == '0)
        begin
            n_next = NW'(1);
        end
        else if (32'(slots_in_use_reg) > 32'(TABLE_SLOTS))
        begin
            n_next = NW'(TABLE_SLOTS);
        end
        else
        begin
            n_next = NW'(slots_in_use_reg);
        end
    end

    always_comb
    begin
        rd_key    = ram_rdata[CNT_W +: KEY_W];
        rd_cnt    = ram_rdata[CNT_W-1:0];
        rd_match  = (rd_key == acc_key);
        rd_empty  = (rd_key == '0);
        idx_inc   = {1'b0, idx_reg} + 1'b1;
        sum_wide  = {1'b0, hit_cnt_reg} + (CNT_W + 1)'(add_reg);
        sum_sat   = sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];
        do_insert = (state_reg == ST_UPDATE) && !full_reg && (mode_reg == MODE_INSERT);
    end

    // RAM port: sweep zeros after reset, otherwise follow the probe index.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_addr  = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = do_insert;
            ram_addr  = idx_reg;
            ram_wdata = {acc_key, sum_sat};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            slots_in_use_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            distinct_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Drop the taken word unless a new one loads behind it.
            if (out_valid_reg && !out_stall && state_reg != ST_PUBLISH)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if ({1'b0, clr_addr_reg} == NW'(TABLE_SLOTS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_acc && last_char)
                    begin
                        mode_reg  <= mode_t'(mode);
                        add_reg   <= add_count;
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO:
                begin
                    n_reg     <= n_next;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                    begin
                        idx_reg       <= SLOT_W'(div_rem);
                        probe_cnt_reg <= '0;
                        state_reg     <= ST_PROBE_RD;
                    end
                end
                ST_PROBE_RD:
                begin
                    state_reg <= ST_PROBE_CHK;
                end
                ST_PROBE_CHK:
                begin
                    if (rd_match || rd_empty)
                    begin
                        hit_match_reg <= rd_match;
                        hit_empty_reg <= rd_empty;
                        hit_cnt_reg   <= rd_cnt;
                        full_reg      <= 1'b0;
                        state_reg     <= ST_UPDATE;
                    end
                    else if (probe_cnt_reg == n_reg - 1'b1)
                    begin
                        // One full pass without a hit: give up.
                        full_reg  <= 1'b1;
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        idx_reg       <= (idx_inc == n_reg) ? '0 : idx_inc[SLOT_W-1:0];
                        probe_cnt_reg <= probe_cnt_reg + 1'b1;
                        state_reg     <= ST_PROBE_RD;
                    end
                end
                ST_UPDATE:
                begin
                    res_slot_reg <= idx_reg;
                    if (do_insert)
                    begin
                        res_found_reg <= 1'b1;
                        res_new_reg   <= hit_empty_reg;
                        res_cnt_reg   <= sum_sat;
                        if (hit_empty_reg)
                        begin
                            distinct_reg <= distinct_reg + 1'b1;
                        end
                    end
                    else if (!full_reg && hit_match_reg)
                    begin
                        res_found_reg <= 1'b1;
                        res_new_reg   <= 1'b0;
                        res_cnt_reg   <= hit_cnt_reg;
                    end
                    else
                    begin
                        res_found_reg <= 1'b0;
                        res_new_reg   <= 1'b0;
                        res_cnt_reg   <= '0;
                    end
                    state_reg <= ST_PUBLISH;
                end
                ST_PUBLISH:
                begin
                    // Hold until the previous result has been taken.
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_slot_reg  <= res_found_reg ?
                                         OUT_SLOT_W'({1'b0, res_slot_reg} + 1'b1) : '0;
                        out_new_reg   <= res_new_reg;
                        out_full_reg  <= full_reg;
                        out_dist_reg  <= OUT_DIST_W'(distinct_reg);
                        out_cnt_reg   <= res_cnt_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    kmch_accum #(
        .MAX_KMER_LEN (MAX_KMER_LEN)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_acc),
        .clear     (acc_clear),
        .base_char (base_char),
        .hash      (acc_hash),
        .key       (acc_key)
    );

    kmch_div #(
        .DIVIDEND_W (HASH_W),
        .DIVISOR_W  (NW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (acc_hash),
        .divisor   (n_next),
        .done      (div_done),
        .remainder (div_rem)
    );

    kmch_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_valid      = out_valid_reg;
    assign slot_plus_one  = out_slot_reg;
    assign was_new        = out_new_reg;
    assign table_full     = out_full_reg;
    assign distinct_count = out_dist_reg;
    assign slot_count     = out_cnt_reg;

    `KMCH_ASSERT_IMPL(a_full_has_no_slot, out_valid_reg && out_full_reg,
        out_slot_reg == '0 && !out_new_reg && out_cnt_reg == '0,
        "full table result carries a slot")
    `KMCH_ASSERT_IMPL(a_probe_in_range,
        state_reg == ST_PROBE_RD || state_reg == ST_PROBE_CHK,
        {1'b0, idx_reg} < n_reg && probe_cnt_reg < n_reg,
        "probe index or count outside the active slots")
    `KMCH_ASSERT_IMPL(a_distinct_steps_by_one, distinct_reg != $past(distinct_reg),
        distinct_reg == $past(distinct_reg) + 1'b1 && $past(state_reg) == ST_UPDATE,
        "distinct key total moved other than by one insert")

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for kmer_count_hash_table_top: random k-mer traffic against a table model.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kmch_pkg::*;

    localparam int TABLE_SLOTS  = DEFAULT_TABLE_SLOTS;
    localparam int KMER_MAX     = DEFAULT_MAX_KMER_LEN;
    // Divider plus the longest possible probe walk, with margin.
    localparam int LATENCY_MAX  = 64 + 2 * TABLE_SLOTS;
    localparam int PHASE_WORDS  = 110;
    localparam int POOL_MAX     = 160;
    localparam int LONG_HOLD    = 400;
    localparam int EAGER_WORDS  = 150;
    localparam int PRINT_CAP    = 40;
    // Every word a final word with the longest walk and a long hold-off, three times over.
    localparam int ITEMS_BOUND  = 1000;
    localparam int CYCLE_LIMIT  = 3 * ITEMS_BOUND * (LATENCY_MAX + LONG_HOLD);

    typedef logic [CHAR_W-1:0] char_seq_t [$];

    typedef struct packed {
        logic [OUT_SLOT_W-1:0] slot_plus_one;
        logic                  was_new;
        logic                  table_full;
        logic [OUT_DIST_W-1:0] distinct_count;
        logic [CNT_W-1:0]      slot_count;
    } kmer_result_t;

    typedef enum {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_t;

    // Mirror of the hash table: accumulates each k-mer, probes on its final word
    // and keeps the lookup results still due from the block.
    class kmer_tally;
        logic [63:0]           slot_key  [TABLE_SLOTS];
        logic [CNT_W-1:0]      slot_freq [TABLE_SLOTS];
        logic [HASH_W-1:0]     hash_acc;
        logic [63:0]           packed_acc;
        int unsigned           base_pos;
        logic [OUT_DIST_W-1:0] distinct;
        logic [CFG_W-1:0]      slots_reg;
        kmer_result_t          due_results [$];
        int unsigned           mismatches;

        function new();
            foreach (slot_key[i])
            begin
                slot_key[i]  = '0;
                slot_freq[i] = '0;
            end
            hash_acc   = '0;
            packed_acc = '0;
            base_pos   = 0;
            distinct   = '0;
            slots_reg  = SLOTS_RESET;
            mismatches = 0;
        endfunction

        function void set_slots(logic [CFG_W-1:0] value);
            slots_reg = value;
        endfunction

        function int unsigned pending();
            return due_results.size();
        endfunction

        // Fold one accepted word into the k-mer; on the final word, probe and update.
        function void note_word(mode_t md, logic [CHAR_W-1:0] ch, logic fin,
                                logic [ADD_W-1:0] add);
            logic [1:0]       code;
            logic [63:0]      key;
            logic [CNT_W:0]   sum;
            int unsigned      n;
            int unsigned      idx;
            int unsigned      probes;
            logic             found;
            kmer_result_t     r;

            hash_acc = hash_acc * HASH_MULT + {24'd0, ch};
            if (base_pos < KMER_MAX)
            begin
                case (ch)
                    CHAR_G:  code = CODE_G;
                    CHAR_C:  code = CODE_C;
                    CHAR_T:  code = CODE_T;
                    default: code = CODE_A;
                endcase
                packed_acc = packed_acc | (64'(code) << (2 * base_pos));
                base_pos++;
            end
            if (!fin)
                return;

            key = packed_acc + 64'd1;
            n = slots_reg;
            if (n == 0)
                n = 1;
            if (n > TABLE_SLOTS)
                n = TABLE_SLOTS;
            idx    = hash_acc % n;
            found  = 1'b0;
            probes = 0;
            while (!found && probes < n)
            begin
                if (slot_key[idx] == key || slot_key[idx] == 64'd0)
                    found = 1'b1;
                else
                begin
                    idx = (idx + 1 == n) ? 0 : idx + 1;
                    probes++;
                end
            end

            r = '0;
            if (!found)
                r.table_full = 1'b1;
            else if (md == MODE_INSERT)
            begin
                if (slot_key[idx] == 64'd0)
                begin
                    slot_key[idx] = key;
                    distinct++;
                    r.was_new = 1'b1;
                end
                sum = {1'b0, slot_freq[idx]} + add;
                slot_freq[idx]  = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
                r.slot_plus_one = OUT_SLOT_W'(idx + 1);
                r.slot_count    = slot_freq[idx];
            end
            else if (slot_key[idx] == key)
            begin
                r.slot_plus_one = OUT_SLOT_W'(idx + 1);
                r.slot_count    = slot_freq[idx];
            end
            r.distinct_count = distinct;
            due_results = {due_results, r};

            hash_acc   = '0;
            packed_acc = '0;
            base_pos   = 0;
        endfunction

        function void compare_field(string field, logic [CNT_W-1:0] want,
                                    logic [CNT_W-1:0] got);
            if (want !== got)
            begin
                if (mismatches < PRINT_CAP)
                    $display("[%0t] %s mismatch: expected %0d, actual %0d",
                             $time, field, want, got);
                mismatches++;
            end
        endfunction

        // Compare one accepted result word with the oldest lookup still due.
        function void check_result(kmer_result_t got);
            kmer_result_t want;
            if (due_results.size() == 0)
            begin
                if (mismatches < PRINT_CAP)
                    $display("[%0t] result word with none due: expected nothing, actual %0h",
                             $time, got);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            compare_field("slot_plus_one", CNT_W'(want.slot_plus_one),
                          CNT_W'(got.slot_plus_one));
            compare_field("was_new", CNT_W'(want.was_new), CNT_W'(got.was_new));
            compare_field("table_full", CNT_W'(want.table_full), CNT_W'(got.table_full));
            compare_field("distinct_count", CNT_W'(want.distinct_count),
                          CNT_W'(got.distinct_count));
            compare_field("slot_count", want.slot_count, got.slot_count);
        endfunction
    endclass

    // Clock, reset and block ports; every input starts at a known value.
    logic                  clk            = 1'b0;
    logic                  rst_n          = 1'b0;
    logic                  cfg_wr_en      = 1'b0;
    logic [CFG_W-1:0]      cfg_wr_data    = '0;
    logic                  in_valid       = 1'b0;
    logic                  in_stall;
    logic                  mode           = 1'b0;
    logic [CHAR_W-1:0]     base_char      = '0;
    logic                  last_char      = 1'b0;
    logic [ADD_W-1:0]      add_count      = '0;
    logic                  out_valid;
    logic                  out_stall      = 1'b0;
    logic [OUT_SLOT_W-1:0] slot_plus_one;
    logic                  was_new;
    logic                  table_full;
    logic [OUT_DIST_W-1:0] distinct_count;
    logic [CNT_W-1:0]      slot_count;

    kmer_tally   book;
    char_seq_t   kmer_pool [POOL_MAX];
    int unsigned pool_size   = 0;
    int unsigned words_sent  = 0;
    int unsigned burst_left  = 0;
    int unsigned eager_words = 0;
    int unsigned hold_asked  = 0;

    // Receiver state, owned by the stall process alone.
    int unsigned rx_hold_left = 0;
    int unsigned hold_served  = 0;
    int unsigned rx_run_left  = 0;
    int unsigned rx_tick      = 0;
    rx_style_t   rx_style     = RX_FLOW;

    kmer_count_hash_table_top #(
        .TABLE_SLOTS  (TABLE_SLOTS),
        .MAX_KMER_LEN (KMER_MAX)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .base_char      (base_char),
        .last_char      (last_char),
        .add_count      (add_count),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .slot_plus_one  (slot_plus_one),
        .was_new        (was_new),
        .table_full     (table_full),
        .distinct_count (distinct_count),
        .slot_count     (slot_count)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Sample both channels at the edge: note every accepted input word, check every
    // accepted result word.
    always @(posedge clk)
    begin
        kmer_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.slot_plus_one  = slot_plus_one;
            got.was_new        = was_new;
            got.table_full     = table_full;
            got.distinct_count = distinct_count;
            got.slot_count     = slot_count;
            book.check_result(got);
        end
        if (rst_n && in_valid && !in_stall)
            book.note_word(mode_t'(mode), base_char, last_char, add_count);
    end

    // Receiver stall pattern: switch among free flow, light and heavy random stalls
    // and a fixed duty cycle; serve a long hold-off whenever the stimulus asks.
    always @(posedge clk)
    begin
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served++;
            rx_hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
        begin
            if (rx_run_left == 0)
            begin
                rx_style    = rx_style_t'($urandom_range(0, 3));
                rx_run_left = $urandom_range(16, 256);
            end
            else
                rx_run_left--;
            rx_tick++;
            case (rx_style)
                RX_FLOW:  out_stall <= 1'b0;
                RX_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
                RX_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
                default:  out_stall <= ((rx_tick % 5) < 2);
            endcase
        end
    end

    // Stop a hung run.
    initial
    begin : watchdog
        int unsigned cycles_seen;
        cycles_seen = 0;
        while (cycles_seen < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_seen++;
        end
        $display("kmer_count_hash_table_top regression: fail");
        $finish;
    end

    // Offer one word and hold it until taken. Gaps come between bursts of random
    // length; long bursts give stretches with no idling at all.
    task automatic send_word(input mode_t md, input logic [CHAR_W-1:0] ch,
                             input logic fin, input logic [ADD_W-1:0] add);
        int unsigned gap;
        if (eager_words > 0)
            eager_words--;
        else if (burst_left == 0)
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 300)
                                                     : $urandom_range(1, 20);
        end
        else
            burst_left--;
        in_valid  <= 1'b1;
        mode      <= md;
        base_char <= ch;
        last_char <= fin;
        add_count <= add;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    // Stream a k-mer; mode and add_count on the inner words are junk on purpose.
    task automatic send_seq(input char_seq_t seq, input mode_t md,
                            input logic [ADD_W-1:0] add);
        for (int i = 0; i < seq.size(); i++)
        begin
            if (i == seq.size() - 1)
                send_word(md, seq[i], 1'b1, add);
            else
                send_word(mode_t'($urandom_range(0, 1)), seq[i], 1'b0,
                          ADD_W'($urandom));
        end
    endtask

    task automatic send_str(input string s, input mode_t md, input logic [ADD_W-1:0] add);
        char_seq_t seq;
        for (int i = 0; i < s.len(); i++)
            seq = {seq, CHAR_W'(s[i])};
        send_seq(seq, md, add);
    endtask

    // Drop valid and hold until every lookup due has come back.
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (book.pending() != 0);
        @(posedge clk);
    endtask

    // Write slots_in_use only once the block is idle.
    task automatic write_slots(input logic [CFG_W-1:0] value);
        wait_results_drained();
        repeat (LATENCY_MAX) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        book.set_slots(value);
    endtask

    // Mostly short nucleotide strings, some long enough to overrun the packer,
    // with an occasional arbitrary byte.
    function automatic char_seq_t random_kmer();
        char_seq_t   s;
        int unsigned len;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 85)
            len = $urandom_range(1, 12);
        else if (roll < 95)
            len = $urandom_range(13, 31);
        else
            len = $urandom_range(32, 40);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    s = {s, CHAR_A};
                2, 3:    s = {s, CHAR_C};
                4, 5:    s = {s, CHAR_G};
                6, 7:    s = {s, CHAR_T};
                8:       s = {s, CHAR_N};
                default: s = {s, CHAR_W'($urandom)};
            endcase
        end
        return s;
    endfunction

    function automatic void remember_kmer(input char_seq_t seq);
        if (pool_size < POOL_MAX)
        begin
            kmer_pool[pool_size] = seq;
            pool_size++;
        end
    endfunction

    // One random phase at a given table size. Most traffic reuses known k-mers so
    // that searches hit and inserts accumulate; the rest is fresh k-mers, stray
    // inner words that prefix the next k-mer, and pauses until drained.
    task automatic run_random_phase(input logic [CFG_W-1:0] slots, input bit long_hold);
        int unsigned      first_word;
        int unsigned      roll;
        char_seq_t        seq;
        mode_t            md;
        logic [ADD_W-1:0] add;

        write_slots(slots);
        repeat (10) remember_kmer(random_kmer());
        if (long_hold)
        begin
            // Let the receiver sit still while words keep coming with no gaps,
            // so the block backs up into its input.
            hold_asked  <= hold_asked + 1;
            eager_words = EAGER_WORDS;
        end
        md  = MODE_INSERT;
        add = '0;
        first_word = words_sent;
        while (words_sent - first_word < PHASE_WORDS)
        begin
            roll = $urandom_range(0, 99);
            md   = ($urandom_range(0, 9) < 6) ? MODE_INSERT : MODE_SEARCH;
            case ($urandom_range(0, 9))
                0:       add = '0;
                1:       add = '1;
                default: add = ADD_W'($urandom);
            endcase
            if (roll < 80)
                send_seq(kmer_pool[$urandom_range(0, pool_size - 1)], md, add);
            else if (roll < 90)
            begin
                seq = random_kmer();
                remember_kmer(seq);
                send_seq(seq, md, add);
            end
            else if (roll < 97)
                repeat ($urandom_range(1, 4))
                    send_word(mode_t'($urandom_range(0, 1)), CHAR_W'($urandom), 1'b0,
                              ADD_W'($urandom));
            else
                wait_results_drained();
        end
        // Close any stray prefix so the phase ends on a final word.
        send_seq(kmer_pool[$urandom_range(0, pool_size - 1)], md, add);
    endtask

    initial
    begin : stimulus
        char_seq_t odd_byte;
        logic [CFG_W-1:0] phase_slots [8];

        phase_slots = '{13'd8191, 13'd37, 13'd4096, 13'd2, 13'd700, 13'd1, 13'd4097, 13'd0};
        phase_slots[7] = CFG_W'($urandom_range(1, TABLE_SLOTS));
        book = new();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Full-size table from reset: every base code, A and N sharing a key under
        // different hashes, count extremes, search hit and miss, non-nucleotide bytes.
        send_str("A", MODE_INSERT, 16'd1);
        send_str("N", MODE_INSERT, 16'd2);
        send_str("A", MODE_INSERT, 16'hFFFF);
        send_str("A", MODE_SEARCH, 16'd0);
        send_str("G", MODE_SEARCH, 16'hFFFF);
        send_str("C", MODE_INSERT, 16'd0);
        send_str("T", MODE_INSERT, 16'hFFFF);
        odd_byte = {odd_byte, 8'h00};
        send_seq(odd_byte, MODE_INSERT, 16'd7);
        odd_byte[0] = 8'hFF;
        send_seq(odd_byte, MODE_INSERT, 16'd9);
        send_str("GCT", MODE_INSERT, 16'd3);

        // Three slots: fill them, then an insert and a search both run a full pass.
        write_slots(13'd3);
        send_str("G", MODE_INSERT, 16'd4);
        send_str("C", MODE_INSERT, 16'd5);
        send_str("T", MODE_INSERT, 16'd6);
        send_str("GG", MODE_INSERT, 16'd8);
        send_str("TT", MODE_SEARCH, 16'd0);

        // Zero acts as a one-slot table.
        write_slots(13'd0);
        send_str("T", MODE_INSERT, 16'd10);
        send_str("A", MODE_INSERT, 16'd11);
        send_str("T", MODE_SEARCH, 16'd0);

        // Random phases over table sizes, both ends and out of range included;
        // keys left from earlier sizes stay in the table.
        for (int p = 0; p < 8; p++)
            run_random_phase(phase_slots[p], p == 2);

        wait_results_drained();
        repeat (LATENCY_MAX) @(posedge clk);
        if (book.mismatches == 0 && book.pending() == 0)
            $display("kmer_count_hash_table_top regression: pass");
        else
            $display("kmer_count_hash_table_top regression: fail");
        $finish;
    end

endmodule
